// File: rtl/core/waypoint_heading_distance_assert.svh
// Assertion macros shared by the pose tracker RTL.
`ifndef WAYPOINT_HEADING_DISTANCE_ASSERT_SVH
`define WAYPOINT_HEADING_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define WHD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define WHD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/whd_pkg.sv
package whd_pkg;

    // Number of CORDIC vectoring iterations and the size of the arctangent table.
    localparam int CORDIC_STEPS = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int STEPS_USED   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int STEP_W       = $clog2(ATAN_ENTRIES);

    // Datapath widths: 17-bit offsets, 36-bit CORDIC vector, 32-bit angle.
    localparam int OFS_W    = 17;
    localparam int VEC_W    = 36;
    localparam int ANGLE_W  = 32;
    localparam int RAD_W    = 2 * OFS_W;
    localparam int ROOT_W   = OFS_W;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    // atan(2^-i) as a fraction of a turn, 2^32 equals one turn.
    localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Operation codes of an input word.
    localparam logic OP_SET_POS = 1'b0;
    localparam logic OP_MOVE    = 1'b1;

    typedef struct packed {
        logic              op;
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
    } whd_item_t;

    typedef struct packed {
        logic        [15:0] distance;
        logic        [15:0] heading;
        logic signed [15:0] heading_change;
    } whd_result_t;

    // Status of an iterative arithmetic unit.
    typedef struct packed {
        logic busy;
        logic done;
    } whd_unit_status_t;

endpackage

// File: rtl/core/whd_cordic.sv
module whd_cordic (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [whd_pkg::OFS_W-1:0]  dx,
    input  logic signed [whd_pkg::OFS_W-1:0]  dy,
    output whd_pkg::whd_unit_status_t         status,
    output logic        [15:0]                heading
);
    import whd_pkg::*;

    logic signed [VEC_W-1:0]   x_reg, x_next;
    logic signed [VEC_W-1:0]   y_reg, y_next;
    logic        [ANGLE_W-1:0] z_reg, z_next;
    logic        [STEP_W-1:0]  step_reg, step_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    logic signed [VEC_W-1:0]   dx_ext, dy_ext;
    logic signed [VEC_W-1:0]   x_shift, y_shift;
    logic        [ANGLE_W-1:0] z_round;

    // Offsets scaled by 2^16; a left half-plane vector is turned by half a turn first.
    assign dx_ext = VEC_W'(dx) <<< 16;
    assign dy_ext = VEC_W'(dy) <<< 16;

    assign x_shift = x_reg >>> step_reg;
    assign y_shift = y_reg >>> step_reg;

    // One micro-rotation per cycle toward the x axis.
    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            x_next    = dx[OFS_W-1] ? -dx_ext : dx_ext;
            y_next    = dx[OFS_W-1] ? -dy_ext : dy_ext;
            z_next    = dx[OFS_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}} : '0;
            step_next = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (!y_reg[VEC_W-1]) begin
                x_next = x_reg + y_shift;
                y_next = y_reg - x_shift;
                z_next = z_reg + ATAN_TURNS[step_reg];
            end else begin
                x_next = x_reg - y_shift;
                y_next = y_reg + x_shift;
                z_next = z_reg - ATAN_TURNS[step_reg];
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(STEPS_USED - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Round the 32-bit angle to 16 bits, nearest.
    assign z_round     = z_reg + ANGLE_W'(32'h8000);
    assign heading     = z_round[ANGLE_W-1 -: 16];
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// File: rtl/core/whd_isqrt.sv
module whd_isqrt (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic        [whd_pkg::RAD_W-1:0]   radicand,
    output whd_pkg::whd_unit_status_t          status,
    output logic        [whd_pkg::ROOT_W-1:0]  root
);
    import whd_pkg::*;

    logic [RAD_W-1:0]      n_reg, n_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic [ROOT_W-1:0]     root_reg, root_next;
    logic [SQRT_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  round_reg, round_next;
    logic                  done_reg, done_next;

    logic [REM_W-1:0]      rem_shift;
    logic [REM_W-1:0]      trial;

    // Bring down the next two radicand bits and try the next root bit.
    assign rem_shift = {rem_reg[REM_W-3:0], n_reg[RAD_W-1 -: 2]};
    assign trial     = REM_W'({root_reg, 2'b01});

    // Restoring square root, one root bit per cycle, then round to nearest.
    always_comb begin
        n_next     = n_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        round_next = round_reg;
        done_next  = done_reg;
        if (start) begin
            n_next     = radicand;
            rem_next   = '0;
            root_next  = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
            round_next = 1'b0;
            done_next  = 1'b0;
        end else if (round_reg) begin
            // The remainder exceeds the root exactly when the true root is past the half.
            if (rem_reg > REM_W'(root_reg)) begin
                root_next = root_reg + 1'b1;
            end
            round_next = 1'b0;
            done_next  = 1'b1;
        end else if (busy_reg) begin
            n_next = n_reg << 2;
            if (rem_shift >= trial) begin
                rem_next  = rem_shift - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_shift;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
                busy_next  = 1'b0;
                round_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            round_reg <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            busy_reg  <= busy_next;
            round_reg <= round_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root        = root_reg;
    assign status.busy = busy_reg | round_reg;
    assign status.done = done_reg;

endmodule

// File: rtl/core/waypoint_heading_distance.sv
// Pose tracker. Each input word either loads the stored position (op 0) or gives a
// target point (op 1); every word yields one result word with the distance to the
// target, the absolute heading of the offset (65536 = one turn) and the signed change
// from the stored heading, after which the target and new heading are stored. A
// set-position word, or a move with zero offset, goes straight to the finish state
// without the arithmetic units. For any other move, one shared multiplier squares
// dx and then dy, then a 17-step restoring square root plus a rounding step sets the
// length, while a 16-iteration CORDIC vectoring unit finds the heading alongside it.
// s_ready is high only between words; a finished result waits in the output register
// while the next word is taken in.
`include "waypoint_heading_distance_assert.svh"

module waypoint_heading_distance (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  whd_pkg::whd_item_t    s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output whd_pkg::whd_result_t  m_data
);
    import whd_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQX  = 3'd1;
    localparam logic [2:0] ST_SQY  = 3'd2;
    localparam logic [2:0] ST_ROOT = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [15:0]              pos_x_reg, pos_y_reg;
    logic [15:0]              pose_heading_reg;
    logic signed [OFS_W-1:0]  dx_reg, dy_reg;
    logic                     skip_reg;
    logic [RAD_W-1:0]         sqx_reg, sqy_reg;
    logic                     m_valid_reg;
    whd_result_t              m_data_reg;

    logic                     s_fire;
    logic                     out_free;
    logic                     fin_load;
    logic signed [OFS_W-1:0]  dx_next, dy_next;
    logic signed [OFS_W-1:0]  mult_op;
    logic signed [RAD_W-1:0]  product;
    logic [RAD_W-1:0]         radicand;
    whd_result_t              result;

    whd_unit_status_t         cordic_st, sqrt_st;
    logic [15:0]              cordic_heading;
    logic [ROOT_W-1:0]        sqrt_root;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign fin_load = (state_reg == ST_FIN) && out_free;

    // Offset from the stored position, 17 bits so it cannot overflow.
    assign dx_next = OFS_W'(s_data.target_x) - OFS_W'($signed(pos_x_reg));
    assign dy_next = OFS_W'(s_data.target_y) - OFS_W'($signed(pos_y_reg));

    // Shared multiplier: squares dx, then dy.
    assign mult_op  = (state_reg == ST_SQX) ? dx_reg : dy_reg;
    assign product  = RAD_W'(mult_op * mult_op);
    assign radicand = sqx_reg + sqy_reg;

    whd_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == ST_SQX),
        .dx      (dx_reg),
        .dy      (dy_reg),
        .status  (cordic_st),
        .heading (cordic_heading)
    );

    whd_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_ROOT),
        .radicand (radicand),
        .status   (sqrt_st),
        .root     (sqrt_root)
    );

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_data.op == OP_SET_POS || (dx_next == '0 && dy_next == '0)) begin
                        state_next = ST_FIN;
                    end else begin
                        state_next = ST_SQX;
                    end
                end
            end
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_ROOT;
            ST_ROOT: state_next = ST_WAIT;
            ST_WAIT: begin
                if (cordic_st.done && sqrt_st.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Result word: saturated distance, rounded heading and wrapped heading change.
    always_comb begin
        if (skip_reg) begin
            result.distance       = '0;
            result.heading        = pose_heading_reg;
            result.heading_change = '0;
        end else begin
            result.distance       = (sqrt_root > ROOT_W'(16'hFFFF)) ? 16'hFFFF
                                                                   : sqrt_root[15:0];
            result.heading        = cordic_heading;
            result.heading_change = $signed(cordic_heading - pose_heading_reg);
        end
    end

    // Control state and pose.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            pos_x_reg        <= '0;
            pos_y_reg        <= '0;
            pose_heading_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (s_fire) begin
                pos_x_reg <= s_data.target_x;
                pos_y_reg <= s_data.target_y;
            end
            if (fin_load) begin
                pose_heading_reg <= result.heading;
                m_valid_reg      <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            skip_reg <= (s_data.op == OP_SET_POS) || (dx_next == '0 && dy_next == '0);
        end
        if (state_reg == ST_SQX) begin
            sqx_reg <= product;
        end
        if (state_reg == ST_SQY) begin
            sqy_reg <= product;
        end
        if (fin_load) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `WHD_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, s_fire, state_reg != ST_IDLE, "accepted word did not start the sequencer")
    `WHD_ASSERT_SAME(a_wait_units_active, aclk, aresetn, state_reg == ST_WAIT, (cordic_st.busy || cordic_st.done) && (sqrt_st.busy || sqrt_st.done), "waiting on an arithmetic unit that was never started")
    `WHD_ASSERT_NEXT(a_fin_delivers, aclk, aresetn, fin_load, m_valid_reg && state_reg == ST_IDLE, "finished word not placed in the output register")
    `WHD_ASSERT_SAME(a_skip_no_units, aclk, aresetn, state_reg == ST_FIN && skip_reg, !cordic_st.busy && !sqrt_st.busy, "arithmetic unit busy on a word that needs none")

endmodule
